// ===== hw/rtl/pmq_pkg.sv =====
// ----------------------------------------------------------------------------
// pmq_pkg: shared types and constants for the pose to quaternion converter
// Holds the register indexes, fixed-point constants and the stage word types.
// ----------------------------------------------------------------------------
`default_nettype none
package pmq_pkg;

   localparam int unsigned DataWidth = 32;
   localparam int unsigned VecWidth  = 34;
   localparam int unsigned SumWidth  = 64;
   localparam int unsigned RootWidth = 32;
   localparam int unsigned QuotWidth = 62;
   localparam int unsigned AddrWidth = 4;

   localparam logic [AddrWidth-1:0] RegInvertX = 4'd0;
   localparam logic [AddrWidth-1:0] RegInvertZ = 4'd4;
   localparam logic [AddrWidth-1:0] RegSwapXz  = 4'd8;

   localparam logic signed [VecWidth-1:0] QOne = 34'sd1073741824;
   localparam logic signed [DataWidth-1:0] MaxPos = 32'sh7fffffff;
   localparam logic signed [DataWidth-1:0] MinNeg = 32'sh80000000;

   typedef struct packed {
      logic invert_x;
      logic invert_z;
      logic swap_xz;
   } cfg_type;

   typedef struct packed {
      logic signed [DataWidth-1:0] pos_x;
      logic signed [DataWidth-1:0] pos_y;
      logic signed [DataWidth-1:0] pos_z;
   } pos_type;

   // Unnormalized quaternion vector: x, y, z, w; each below 2^31 in magnitude.
   typedef struct packed {
      logic [3:0]           neg;
      logic [3:0][30:0]     mag;
   } vec_type;

   function automatic logic signed [DataWidth-1:0] neg_sat(
      input logic signed [DataWidth-1:0] v
   );
      neg_sat = (v == MinNeg) ? MaxPos : -v;
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/pose_matrix_to_position_quaternion.sv =====
// ----------------------------------------------------------------------------
// pose_matrix_to_position_quaternion: pose to position and unit quaternion
// Throughput: one word per cycle while the output is not stalled; a single advance enable steps all stages.
// The root (32 stages) and the divider (62 stages) set the depth.
// Reset clears the valid bits and the configuration registers only.
// ----------------------------------------------------------------------------
`default_nettype none
module pose_matrix_to_position_quaternion
   import pmq_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic      req_stall,
   input  wire logic signed [31:0] req_rot_00, req_rot_01, req_rot_02,
   input  wire logic signed [31:0] req_rot_10, req_rot_11, req_rot_12,
   input  wire logic signed [31:0] req_rot_20, req_rot_21, req_rot_22,
   input  wire logic signed [31:0] req_trans_x, req_trans_y, req_trans_z,
   output logic      rsp_valid,
   input  wire logic rsp_stall,
   output logic signed [31:0] rsp_pos_x, rsp_pos_y, rsp_pos_z,
   output logic signed [31:0] rsp_quat_x, rsp_quat_y, rsp_quat_z, rsp_quat_w,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   // Stage count: two front, two squares/sum, root, divider, output.
   localparam int unsigned Depth = 2 + 2 + 32 + 62 + 1;

   cfg_type cfg_ff;
   logic    advance;
   logic [Depth-1:0] vld_ff;
   vec_type vec;
   pos_type pos_a, pos_b;
   logic [3:0][DataWidth-1:0] quat;

   assign csr_pready = 1'b1;

   // Register writes complete on the access cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         case (csr_paddr)
            RegInvertX: cfg_ff.invert_x <= csr_pwdata[0];
            RegInvertZ: cfg_ff.invert_z <= csr_pwdata[0];
            RegSwapXz:  cfg_ff.swap_xz  <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr)
         RegInvertX: csr_prdata = {31'd0, cfg_ff.invert_x};
         RegInvertZ: csr_prdata = {31'd0, cfg_ff.invert_z};
         RegSwapXz:  csr_prdata = {31'd0, cfg_ff.swap_xz};
         default:    csr_prdata = '0;
      endcase
   end

   // Hold the whole pipe while the last word is stalled at the output.
   assign advance   = !(vld_ff[Depth-1] && rsp_stall);
   assign req_stall = !advance;
   assign rsp_valid = vld_ff[Depth-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[Depth-2:0], req_valid};
      end
   end

   pmq_front u_front (
      .clock   (clock),
      .advance (advance),
      .cfg     (cfg_ff),
      .rot     ({req_rot_22, req_rot_21, req_rot_20, req_rot_12, req_rot_11,
                 req_rot_10, req_rot_02, req_rot_01, req_rot_00}),
      .pos_in  ({req_trans_x, req_trans_y, req_trans_z}),
      .vec_out (vec),
      .pos_out (pos_a)
   );

   pmq_norm u_norm (
      .clock    (clock),
      .advance  (advance),
      .vec_in   (vec),
      .pos_in   (pos_a),
      .quat_out (quat),
      .pos_out  (pos_b)
   );

   assign rsp_pos_x  = pos_b.pos_x;
   assign rsp_pos_y  = pos_b.pos_y;
   assign rsp_pos_z  = pos_b.pos_z;
   assign rsp_quat_x = quat[0];
   assign rsp_quat_y = quat[1];
   assign rsp_quat_z = quat[2];
   assign rsp_quat_w = quat[3];

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without a blocked output word");
   a_hold_output: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_quat_w))
      else $error("stalled output word changed");
   a_zero_valid_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("output valid right after reset");

endmodule
`default_nettype wire

// ===== hw/rtl/pmq_front.sv =====
// ----------------------------------------------------------------------------
// pmq_front: row flips and swap, Shepperd branch selection and magnitude scaling
// Two register stages: branch vector, then scaled sign and magnitude.
// ----------------------------------------------------------------------------
`default_nettype none
module pmq_front
   import pmq_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 advance,
   input  wire cfg_type              cfg,
   input  wire logic [8:0][DataWidth-1:0] rot,
   input  wire pos_type              pos_in,
   output vec_type                   vec_out,
   output pos_type                   pos_out
);

   logic signed [DataWidth-1:0] m [3][4];
   logic signed [DataWidth-1:0] a [3][4];
   logic signed [VecWidth-1:0]  d00, d11, d22, t, r2;
   logic signed [VecWidth-1:0]  v_in [4];
   logic signed [VecWidth-1:0]  v_ff [4];
   pos_type                     p1_in, p1_ff;
   logic [33:0]                 mag_w [4];
   logic [33:0]                 mx;
   logic [1:0]                  sh;
   vec_type                     vec_in, vec_ff;
   pos_type                     pos_ff;

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            a[r][c] = rot[r*3+c];
         end
      end
      a[0][3] = pos_in.pos_x;
      a[1][3] = pos_in.pos_y;
      a[2][3] = pos_in.pos_z;
      for (int c = 0; c < 4; c++) begin
         if (cfg.invert_x) a[0][c] = neg_sat(a[0][c]);
         if (cfg.invert_z) a[2][c] = neg_sat(a[2][c]);
      end
      for (int c = 0; c < 4; c++) begin
         m[0][c] = cfg.swap_xz ? a[2][c] : a[0][c];
         m[1][c] = a[1][c];
         m[2][c] = cfg.swap_xz ? a[0][c] : a[2][c];
      end
      d00 = VecWidth'(m[0][0]);
      d11 = VecWidth'(m[1][1]);
      d22 = VecWidth'(m[2][2]);
      t = d00 + d11 + d22;
      r2 = '0;
      if (t > 0) begin
         v_in[3] = QOne + t;
         v_in[0] = VecWidth'(m[2][1]) - VecWidth'(m[1][2]);
         v_in[1] = VecWidth'(m[0][2]) - VecWidth'(m[2][0]);
         v_in[2] = VecWidth'(m[1][0]) - VecWidth'(m[0][1]);
      end else if (d00 > d11 && d00 > d22) begin
         r2 = QOne + d00 - d11 - d22;
         v_in[0] = (r2 > 0) ? r2 : '0;
         v_in[3] = VecWidth'(m[2][1]) - VecWidth'(m[1][2]);
         v_in[1] = VecWidth'(m[0][1]) + VecWidth'(m[1][0]);
         v_in[2] = VecWidth'(m[0][2]) + VecWidth'(m[2][0]);
      end else if (d11 > d22) begin
         r2 = QOne + d11 - d00 - d22;
         v_in[1] = (r2 > 0) ? r2 : '0;
         v_in[3] = VecWidth'(m[0][2]) - VecWidth'(m[2][0]);
         v_in[0] = VecWidth'(m[0][1]) + VecWidth'(m[1][0]);
         v_in[2] = VecWidth'(m[1][2]) + VecWidth'(m[2][1]);
      end else begin
         r2 = QOne + d22 - d00 - d11;
         v_in[2] = (r2 > 0) ? r2 : '0;
         v_in[3] = VecWidth'(m[1][0]) - VecWidth'(m[0][1]);
         v_in[0] = VecWidth'(m[0][2]) + VecWidth'(m[2][0]);
         v_in[1] = VecWidth'(m[1][2]) + VecWidth'(m[2][1]);
      end
      p1_in.pos_x = m[0][3];
      p1_in.pos_y = m[1][3];
      p1_in.pos_z = m[2][3];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         v_ff  <= v_in;
         p1_ff <= p1_in;
      end
   end

   // Shift all magnitudes right until the largest is below 2^31 (at most 3).
   always_comb begin
      mx = '0;
      for (int i = 0; i < 4; i++) begin
         mag_w[i] = v_ff[i][VecWidth-1] ? 34'(-v_ff[i]) : 34'(v_ff[i]);
         mx = mx | mag_w[i];
      end
      if (mx[33])      sh = 2'd3;
      else if (mx[32]) sh = 2'd2;
      else if (mx[31]) sh = 2'd1;
      else             sh = 2'd0;
      for (int i = 0; i < 4; i++) begin
         vec_in.mag[i] = 31'(mag_w[i] >> sh);
         vec_in.neg[i] = v_ff[i][VecWidth-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         vec_ff <= vec_in;
         pos_ff <= p1_ff;
      end
   end

   assign vec_out = vec_ff;
   assign pos_out = pos_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/pmq_norm.sv =====
// ----------------------------------------------------------------------------
// pmq_norm: squares, root and per-component division, fully pipelined
// Square root takes one result bit per stage, division one quotient bit per
// stage for all four components in parallel.
// ----------------------------------------------------------------------------
`default_nettype none
module pmq_norm
   import pmq_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    advance,
   input  wire vec_type vec_in,
   input  wire pos_type pos_in,
   output logic [3:0][DataWidth-1:0] quat_out,
   output pos_type      pos_out
);

   localparam int unsigned RtStages  = RootWidth;
   localparam int unsigned DvStages  = QuotWidth;

   // Squares stage, then sum stage.
   logic [3:0][61:0] sq_ff;
   vec_type          v0_ff, v1_ff;
   pos_type          p0_ff, p1_ff;
   logic [SumWidth-1:0] sum_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < 4; i++) sq_ff[i] <= vec_in.mag[i] * vec_in.mag[i];
         v0_ff  <= vec_in;
         p0_ff  <= pos_in;
         sum_ff <= 64'(sq_ff[0]) + 64'(sq_ff[1]) + 64'(sq_ff[2]) + 64'(sq_ff[3]);
         v1_ff  <= v0_ff;
         p1_ff  <= p0_ff;
      end
   end

   // Restoring square root, one result bit per stage.
   logic [SumWidth-1:0]  rx_ff [RtStages+1];
   logic [RootWidth-1:0] rr_ff [RtStages+1];
   vec_type              rv_ff [RtStages+1];
   pos_type              rp_ff [RtStages+1];

   always_comb begin
      rx_ff[0] = sum_ff;
      rr_ff[0] = '0;
      rv_ff[0] = v1_ff;
      rp_ff[0] = p1_ff;
   end

   for (genvar s = 0; s < RtStages; s++) begin : g_root
      localparam int unsigned B = RtStages - 1 - s;
      logic [SumWidth-1:0]  trial;
      logic [SumWidth-1:0]  rem_in;
      logic [RootWidth-1:0] root_in;
      always_comb begin
         trial = (64'(rr_ff[s]) << (B + 1)) + (64'd1 << (2 * B));
         if (rx_ff[s] >= trial) begin
            rem_in  = rx_ff[s] - trial;
            root_in = rr_ff[s] | (RootWidth'(1) << B);
         end else begin
            rem_in  = rx_ff[s];
            root_in = rr_ff[s];
         end
      end
      always_ff @(posedge clock) begin
         if (advance) begin
            rx_ff[s+1] <= rem_in;
            rr_ff[s+1] <= root_in;
            rv_ff[s+1] <= rv_ff[s];
            rp_ff[s+1] <= rp_ff[s];
         end
      end
   end

   // Long division of (mag << 30) + n/2 by n, one quotient bit per stage.
   logic [RootWidth-1:0]            dn_ff [DvStages+1];
   logic [3:0][QuotWidth-1:0]       dd_ff [DvStages+1];
   logic [3:0][RootWidth:0]         dr_ff [DvStages+1];
   logic [3:0][QuotWidth-1:0]       dq_ff [DvStages+1];
   logic [3:0]                      dg_ff [DvStages+1];
   pos_type                         dp_ff [DvStages+1];

   always_comb begin
      dn_ff[0] = rr_ff[RtStages];
      for (int i = 0; i < 4; i++) begin
         dd_ff[0][i] = (62'(rv_ff[RtStages].mag[i]) << 30) +
                       62'(rr_ff[RtStages] >> 1);
         dr_ff[0][i] = '0;
         dq_ff[0][i] = '0;
      end
      dg_ff[0] = rv_ff[RtStages].neg;
      dp_ff[0] = rp_ff[RtStages];
   end

   for (genvar s = 0; s < DvStages; s++) begin : g_div
      localparam int unsigned B = DvStages - 1 - s;
      logic [3:0][RootWidth+1:0] shr;
      logic [3:0][RootWidth:0]   rem_in;
      logic [3:0][QuotWidth-1:0] quo_in;
      always_comb begin
         for (int i = 0; i < 4; i++) begin
            shr[i] = {dr_ff[s][i], dd_ff[s][i][B]};
            quo_in[i] = dq_ff[s][i];
            if (shr[i] >= 34'(dn_ff[s])) begin
               rem_in[i] = 33'(shr[i] - 34'(dn_ff[s]));
               quo_in[i][B] = 1'b1;
            end else begin
               rem_in[i] = 33'(shr[i]);
            end
         end
      end
      always_ff @(posedge clock) begin
         if (advance) begin
            dn_ff[s+1] <= dn_ff[s];
            dd_ff[s+1] <= dd_ff[s];
            dr_ff[s+1] <= rem_in;
            dq_ff[s+1] <= quo_in;
            dg_ff[s+1] <= dg_ff[s];
            dp_ff[s+1] <= dp_ff[s];
         end
      end
   end

   // Saturate, restore sign; zero length gives a zero quaternion.
   logic [3:0][DataWidth-1:0] q_in, q_ff;
   pos_type                   po_ff;
   logic [DataWidth-2:0]      qm;
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         qm = (dq_ff[DvStages][i] > 62'(MaxPos)) ? 31'h7fffffff
                                                 : dq_ff[DvStages][i][30:0];
         if (dn_ff[DvStages] == '0) q_in[i] = '0;
         else q_in[i] = dg_ff[DvStages][i] ? -{1'b0, qm} : {1'b0, qm};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         q_ff  <= q_in;
         po_ff <= dp_ff[DvStages];
      end
   end

   assign quat_out = q_ff;
   assign pos_out  = po_ff;

endmodule
`default_nettype wire

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb: pose to position and quaternion converter testbench
// Drives poses through the req channel with random gaps, stalls the rsp
// channel at random, predicts each word in a local model of the converter
// and compares the position and quaternion fields in order of arrival.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
module tb
   import pmq_pkg::*;
;

   localparam int Latency = 100;
   localparam longint CycleLimit = 2000000;
   localparam longint Lim31 = 64'sd2147483648;
   localparam longint One30 = 64'sd1073741824;

   typedef struct {
      logic signed [31:0] rot[9];
      logic signed [31:0] trans[3];
   } pose_type;

   typedef struct {
      logic signed [31:0] pos[3];
      logic signed [31:0] quat[4];
   } result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [31:0] req_rot[9];
   logic signed [31:0] req_trans[3];
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [31:0] rsp_pos_x, rsp_pos_y, rsp_pos_z;
   logic signed [31:0] rsp_quat_x, rsp_quat_y, rsp_quat_z, rsp_quat_w;
   logic csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [3:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   // Local copy of the configuration that the predictor applies.
   cfg_type cfg_model = '0;
   result_type expected_words[$];
   int mismatch_count = 0;
   bit stall_enable = 1'b1;
   longint cycle_count = 0;

   initial begin
      for (int i = 0; i < 9; i++) req_rot[i] = '0;
      for (int i = 0; i < 3; i++) req_trans[i] = '0;
   end

   pose_matrix_to_position_quaternion dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_rot_00(req_rot[0]), .req_rot_01(req_rot[1]), .req_rot_02(req_rot[2]),
      .req_rot_10(req_rot[3]), .req_rot_11(req_rot[4]), .req_rot_12(req_rot[5]),
      .req_rot_20(req_rot[6]), .req_rot_21(req_rot[7]), .req_rot_22(req_rot[8]),
      .req_trans_x(req_trans[0]), .req_trans_y(req_trans[1]),
      .req_trans_z(req_trans[2]),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_pos_x(rsp_pos_x), .rsp_pos_y(rsp_pos_y), .rsp_pos_z(rsp_pos_z),
      .rsp_quat_x(rsp_quat_x), .rsp_quat_y(rsp_quat_y),
      .rsp_quat_z(rsp_quat_z), .rsp_quat_w(rsp_quat_w),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Abort on a hung pipeline.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("tb: failure");
         $finish;
      end
   end

   function automatic longint negate_saturate(longint v);
      return (v == -Lim31) ? Lim31 - 1 : -v;
   endfunction

   function automatic longint unsigned magnitude(longint v);
      return (v < 0) ? longint'(-v) : longint'(v);
   endfunction

   function automatic longint unsigned int_root(longint unsigned x);
      longint unsigned root;
      longint unsigned probe;
      root = 0;
      probe = 64'd1 << 62;
      while (probe > x) probe >>= 2;
      while (probe != 0) begin
         if (x >= root + probe) begin
            x -= root + probe;
            root = (root >> 1) + probe;
         end else begin
            root >>= 1;
         end
         probe >>= 2;
      end
      return root;
   endfunction

   // Flip and swap the rows, then form the scaled quaternion by Shepperd's
   // method, shrink it below 2^31 and normalize with rounding.
   function automatic result_type convert_pose(pose_type p, cfg_type c);
      result_type res;
      longint m[3][4];
      longint vec[4];
      longint tr, rad, tmp;
      longint unsigned big, sq_sum, len, a;
      for (int r = 0; r < 3; r++) begin
         for (int k = 0; k < 3; k++) m[r][k] = longint'(p.rot[r*3+k]);
         m[r][3] = longint'(p.trans[r]);
      end
      if (c.invert_x) for (int k = 0; k < 4; k++) m[0][k] = negate_saturate(m[0][k]);
      if (c.invert_z) for (int k = 0; k < 4; k++) m[2][k] = negate_saturate(m[2][k]);
      if (c.swap_xz) begin
         for (int k = 0; k < 4; k++) begin
            tmp = m[0][k]; m[0][k] = m[2][k]; m[2][k] = tmp;
         end
      end
      tr = m[0][0] + m[1][1] + m[2][2];
      if (tr > 0) begin
         vec[3] = One30 + tr;
         vec[0] = m[2][1] - m[1][2];
         vec[1] = m[0][2] - m[2][0];
         vec[2] = m[1][0] - m[0][1];
      end else if (m[0][0] > m[1][1] && m[0][0] > m[2][2]) begin
         rad = One30 + m[0][0] - m[1][1] - m[2][2];
         vec[0] = (rad > 0) ? rad : 0;
         vec[3] = m[2][1] - m[1][2];
         vec[1] = m[0][1] + m[1][0];
         vec[2] = m[0][2] + m[2][0];
      end else if (m[1][1] > m[2][2]) begin
         rad = One30 + m[1][1] - m[0][0] - m[2][2];
         vec[1] = (rad > 0) ? rad : 0;
         vec[3] = m[0][2] - m[2][0];
         vec[0] = m[0][1] + m[1][0];
         vec[2] = m[1][2] + m[2][1];
      end else begin
         rad = One30 + m[2][2] - m[0][0] - m[1][1];
         vec[2] = (rad > 0) ? rad : 0;
         vec[3] = m[1][0] - m[0][1];
         vec[0] = m[0][2] + m[2][0];
         vec[1] = m[1][2] + m[2][1];
      end
      big = 0;
      for (int i = 0; i < 4; i++) if (magnitude(vec[i]) > big) big = magnitude(vec[i]);
      while (big >= Lim31) begin
         for (int i = 0; i < 4; i++) begin
            a = magnitude(vec[i]) >> 1;
            vec[i] = (vec[i] < 0) ? -longint'(a) : longint'(a);
         end
         big >>= 1;
      end
      sq_sum = 0;
      for (int i = 0; i < 4; i++) sq_sum += magnitude(vec[i]) * magnitude(vec[i]);
      len = int_root(sq_sum);
      for (int i = 0; i < 3; i++) res.pos[i] = m[i][3][31:0];
      for (int i = 0; i < 4; i++) begin
         res.quat[i] = '0;
         if (len != 0) begin
            a = ((magnitude(vec[i]) << 30) + (len >> 1)) / len;
            if (a > Lim31 - 1) a = Lim31 - 1;
            res.quat[i] = 32'((vec[i] < 0) ? -longint'(a) : longint'(a));
         end
      end
      return res;
   endfunction

   // Append one prediction behind the words still in flight.
   task automatic queue_word(result_type w);
      expected_words = {expected_words, w};
   endtask

   // Check each rsp word against the oldest prediction.
   always @(posedge clock) begin
      result_type want;
      logic signed [31:0] got[7];
      logic signed [31:0] exp_f[7];
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_pos_x, rsp_pos_y, rsp_pos_z,
                 rsp_quat_x, rsp_quat_y, rsp_quat_z, rsp_quat_w};
         if (expected_words.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("tb: unexpected rsp word");
         end else begin
            want = expected_words.pop_front();
            exp_f = '{want.pos[0], want.pos[1], want.pos[2],
                      want.quat[0], want.quat[1], want.quat[2], want.quat[3]};
            for (int i = 0; i < 7; i++) begin
               if (got[i] !== exp_f[i]) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("tb: field %0d expected %h got %h", i, exp_f[i], got[i]);
               end
            end
         end
      end
   end

   // Stall the rsp side for a random count of cycles per word.
   initial begin
      int hold;
      @(negedge clock);
      forever begin
         hold = stall_enable ? $urandom_range(0, 14) : 0;
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         @(negedge clock);
      end
   end

   task automatic write_reg(logic [3:0] addr, logic [31:0] data);
      @(negedge clock);
      csr_psel <= 1'b1; csr_pwrite <= 1'b1; csr_paddr <= addr; csr_pwdata <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      case (addr)
         RegInvertX: cfg_model.invert_x = data[0];
         RegInvertZ: cfg_model.invert_z = data[0];
         RegSwapXz:  cfg_model.swap_xz = data[0];
         default: ;
      endcase
   endtask

   // Drop the req side, drain the pipeline, then load all three flags.
   task automatic set_flags(bit ix, bit iz, bit sw);
      req_valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      write_reg(RegInvertX, {$urandom_range(0, 1) ? 31'h7fffffff : 31'h0, ix});
      write_reg(RegInvertZ, {31'h0, iz});
      write_reg(RegSwapXz, {31'h0, sw});
   endtask

   // Send one pose word with an optional leading gap; predict at acceptance.
   // Called at a falling edge; returns at the falling edge after acceptance
   // with valid still high so the next word can follow without a gap.
   task automatic send_pose(pose_type p, bit gaps);
      int gap;
      gap = gaps ? $urandom_range(0, 14) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      for (int i = 0; i < 9; i++) req_rot[i] <= p.rot[i];
      for (int i = 0; i < 3; i++) req_trans[i] <= p.trans[i];
      @(posedge clock);
      while (req_stall) @(posedge clock);
      queue_word(convert_pose(p, cfg_model));
      @(negedge clock);
   endtask

   function automatic pose_type identity_pose();
      pose_type p;
      for (int i = 0; i < 9; i++) p.rot[i] = (i % 4 == 0) ? 32'sh40000000 : 32'sh0;
      for (int i = 0; i < 3; i++) p.trans[i] = '0;
      return p;
   endfunction

   // Rotation near a real one: sign-permuted axes plus small noise, with an occasional fully random entry.
   function automatic pose_type random_pose();
      pose_type p;
      int perm[3];
      int k;
      perm = '{0, 1, 2};
      for (int i = 2; i > 0; i--) begin
         k = $urandom_range(0, i);
         {perm[i], perm[k]} = {perm[k], perm[i]};
      end
      for (int i = 0; i < 9; i++) begin
         if ($urandom_range(0, 9) == 0) p.rot[i] = $urandom;
         else p.rot[i] = $signed($urandom_range(0, 2 ** 26)) - 32'sd33554432;
      end
      for (int r = 0; r < 3; r++) begin
         if ($urandom_range(0, 1)) p.rot[r*3+perm[r]] += 32'sh3c000000;
         else p.rot[r*3+perm[r]] -= 32'sh3c000000;
      end
      for (int i = 0; i < 3; i++) p.trans[i] = $urandom;
      return p;
   endfunction

   task automatic test_directed_extremes();
      pose_type p;
      send_pose(identity_pose(), 1'b0);
      // All fields at the most negative value.
      for (int i = 0; i < 9; i++) p.rot[i] = 32'sh80000000;
      for (int i = 0; i < 3; i++) p.trans[i] = 32'sh80000000;
      send_pose(p, 1'b0);
      for (int i = 0; i < 9; i++) p.rot[i] = 32'sh7fffffff;
      for (int i = 0; i < 3; i++) p.trans[i] = 32'sh7fffffff;
      send_pose(p, 1'b0);
      // Zero matrix lands in the last diagonal branch.
      for (int i = 0; i < 9; i++) p.rot[i] = '0;
      send_pose(p, 1'b0);
      // Diagonal branches: 180 degree turns about x, y and z.
      for (int ax = 0; ax < 3; ax++) begin
         p = identity_pose();
         for (int d = 0; d < 3; d++) if (d != ax) p.rot[d*4] = 32'shc0000000;
         p.trans = '{32'sh00010000, 32'shffff0000, 32'sh12345678};
         send_pose(p, 1'b0);
      end
      // Equal negative diagonal entries select the last diagonal branch.
      p = identity_pose();
      p.rot = '{32'shc0000000, 32'sh10000000, 32'sh0, 32'sh10000000, 32'shc0000000,
                32'sh20000000, 32'sh0, 32'sh20000000, 32'shc0000000};
      send_pose(p, 1'b0);
      p.rot = '{32'sh80000000, 32'sh0, 32'sh0, 32'sh0, 32'sh80000000,
                32'sh0, 32'sh0, 32'sh0, 32'sh80000000};
      send_pose(p, 1'b0);
      // Large trace forces the shift below 2^31.
      p.rot = '{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff,
                32'sh7fffffff, 32'sh80000000, 32'sh80000000, 32'sh7fffffff,
                32'sh7fffffff};
      send_pose(p, 1'b0);
      // Walk a set bit through the rot fields and a cleared bit through the trans fields, in steps of five bits.
      for (int b = 0; b < 32; b += 5) begin
         for (int i = 0; i < 9; i++) p.rot[i] = 32'sh1 << ((b + i) % 32);
         for (int i = 0; i < 3; i++) p.trans[i] = ~(32'sh1 << ((b + i) % 32));
         send_pose(p, 1'b0);
      end
   endtask

   task automatic test_flag_settings();
      for (int s = 0; s < 8; s++) begin
         set_flags(s[0], s[1], s[2]);
         repeat (4) send_pose(random_pose(), 1'b1);
      end
   endtask

   task automatic test_random_stream(int count);
      pose_type p;
      for (int n = 0; n < count; n++) begin
         if (n % 120 == 0) set_flags($urandom_range(0, 1), $urandom_range(0, 1),
                                     $urandom_range(0, 1));
         // Full rate stretch without gaps or stalls.
         stall_enable = !(n % 200 < 30);
         if ($urandom_range(0, 9) == 0) begin
            for (int i = 0; i < 9; i++) p.rot[i] = $urandom;
            for (int i = 0; i < 3; i++) p.trans[i] = $urandom;
         end else begin
            p = random_pose();
         end
         send_pose(p, stall_enable && $urandom_range(0, 3) != 0);
      end
      stall_enable = 1'b1;
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed_extremes();
      test_flag_settings();
      test_random_stream(900);
      req_valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (Latency + 20) @(posedge clock);
      if (mismatch_count == 0 && expected_words.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/pmq_pkg.sv
hw/rtl/pmq_front.sv
hw/rtl/pmq_norm.sv
hw/rtl/pose_matrix_to_position_quaternion.sv
verif/tb.sv
